>>> hw/rtl/debounced_photo_position_counter_core_defines.svh
// assertion macros for the position counter core
`ifndef DEBOUNCED_PHOTO_POSITION_COUNTER_CORE_DEFINES_SVH
`define DEBOUNCED_PHOTO_POSITION_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define DPPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define DPPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dppc_pkg.sv
package dppc_pkg;

  localparam int unsigned PosWidth      = 11;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned LostWidth     = 16;
  localparam int unsigned FilterWidth   = 8;
  localparam int unsigned ConfirmWidth  = FilterWidth + 1;
  localparam int unsigned MaxCountWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [PosWidth-1:0]      PosLimit = PosWidth'(2000);
  localparam logic [LostWidth-1:0]     LostMax  = {LostWidth{1'b1}};

  // configuration register indexes
  localparam logic [CfgIndexWidth-1:0] CfgHomeFilter  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgCountFilter = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgHoldoff     = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CfgMaxCount    = 2'd3;

  localparam logic [FilterWidth-1:0]   HomeFilterRst  = 8'd5;
  localparam logic [FilterWidth-1:0]   CountFilterRst = 8'd5;
  localparam logic [FilterWidth-1:0]   HoldoffRst     = 8'd10;
  localparam logic [MaxCountWidth-1:0] MaxCountRst    = 16'd2000;

  typedef struct packed {
    logic home_level;
    logic count_level;
    logic system_enable;
  } in_word_t;

  typedef struct packed {
    logic                     report_valid;
    logic [PosWidth-1:0]      position;
    logic [IntervalWidth-1:0] interval;
    logic [LostWidth-1:0]     lost_count;
    logic                     homed;
  } out_word_t;

  typedef struct packed {
    logic                    stable;
    logic                    cand;
    logic [ConfirmWidth-1:0] conf;
  } deb_state_t;

  typedef struct packed {
    deb_state_t st;
    logic       rise;
  } deb_result_t;

  // one debouncer tick: a new level must persist beyond the filter count
  function automatic deb_result_t debounce(input deb_state_t      cur,
                                           input logic            lvl,
                                           input logic [FilterWidth-1:0] filt);
    deb_result_t             res;
    logic                    cand;
    logic [ConfirmWidth-1:0] conf_inc;
    cand     = (cur.stable != lvl && cur.conf == '0) ? lvl : cur.cand;
    conf_inc = cur.conf + ConfirmWidth'(1);
    res.st   = cur;
    res.rise = 1'b0;
    if (cand == lvl && cand != cur.stable) begin
      res.st.cand = cand;
      if (conf_inc > {1'b0, filt}) begin
        res.st.stable = cand;
        res.st.conf   = '0;
        res.rise      = cand;
      end else begin
        res.st.conf = conf_inc;
      end
    end else begin
      res.st.cand = cur.stable;
      res.st.conf = '0;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/debounced_photo_position_counter_core.sv
// debounced photo position counter core
// input channel: one word per sensor tick (home level, count level, system enable),
//   taken when in_valid_i is high and in_stall_o is low
// output channel: exactly one result word per input word, in order, shown on
//   out_valid_o / out_word_o and taken when out_stall_i is low
// config channel: cfg_valid_i with cfg_index_i / cfg_data_i, always ready;
//   index 0 home filter, 1 count filter, 2 holdoff ticks, 3 max count;
//   write only while no word is in flight
// latency: the result of a word is registered and appears the cycle after it is taken
// throughput: one word per cycle; all debounce, holdoff, position and lost
//   counter updates are done in one cycle of logic feeding the result register
// stall: in_stall_o is high only while a result is held and out_stall_i is high,
//   so a new word is taken in the same cycle the held result leaves
// reset: async active low; debouncers, position, interval, holdoff, lost count
//   and homed are cleared, config returns to 5 / 5 / 10 / 2000, output empty
`include "debounced_photo_position_counter_core_defines.svh"

module debounced_photo_position_counter_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  dppc_pkg::in_word_t                    in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output dppc_pkg::out_word_t                   out_word_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dppc_pkg::CfgIndexWidth-1:0]    cfg_index_i,
  input  logic [dppc_pkg::CfgDataWidth-1:0]     cfg_data_i
);
  import dppc_pkg::*;

  logic [FilterWidth-1:0]   home_filter_q, count_filter_q, holdoff_ticks_q;
  logic [MaxCountWidth-1:0] max_count_q;

  deb_state_t               home_q, home_d, count_q, count_d;
  logic                     homed_q, homed_d;
  logic [PosWidth-1:0]      pos_q, pos_d;
  logic [IntervalWidth-1:0] interval_q, interval_d;
  logic [FilterWidth-1:0]   holdoff_q, holdoff_d;
  logic [LostWidth-1:0]     lost_q, lost_d;

  logic                     out_valid_q;
  out_word_t                out_word_q, out_word_d;

  deb_result_t              home_res, count_res;
  logic                     in_accept, cfg_accept;
  logic                     report;
  logic [IntervalWidth-1:0] interval_inc;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_filter_q   <= HomeFilterRst;
      count_filter_q  <= CountFilterRst;
      holdoff_ticks_q <= HoldoffRst;
      max_count_q     <= MaxCountRst;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        CfgHomeFilter:  home_filter_q   <= cfg_data_i[FilterWidth-1:0];
        CfgCountFilter: count_filter_q  <= cfg_data_i[FilterWidth-1:0];
        CfgHoldoff:     holdoff_ticks_q <= cfg_data_i[FilterWidth-1:0];
        CfgMaxCount:    max_count_q     <= cfg_data_i[MaxCountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    home_res     = debounce(home_q, in_word_i.home_level, home_filter_q);
    count_res    = debounce(count_q, in_word_i.count_level, count_filter_q);
    home_d       = home_res.st;
    count_d      = count_q;
    homed_d      = homed_q;
    pos_d        = pos_q;
    lost_d       = lost_q;
    holdoff_d    = holdoff_q;
    report       = 1'b0;
    interval_inc = interval_q + IntervalWidth'(1);
    interval_d   = interval_inc;

    if (home_res.rise) begin
      homed_d = 1'b1;
      pos_d   = '0;
      lost_d  = '0;
    end

    // count debouncer frozen during holdoff
    if (holdoff_q != '0) begin
      holdoff_d = holdoff_q - FilterWidth'(1);
    end else begin
      count_d = count_res.st;
      if (count_res.rise) begin
        if (pos_d <= PosLimit && homed_d) begin
          pos_d      = pos_d + PosWidth'(1);
          report     = 1'b1;
          interval_d = '0;
          holdoff_d  = holdoff_ticks_q;
        end
        if (MaxCountWidth'(pos_d) > max_count_q && in_word_i.system_enable &&
            lost_d != LostMax) begin
          lost_d = lost_d + LostWidth'(1);
        end
      end
    end

    out_word_d.report_valid = report;
    out_word_d.position     = pos_d;
    out_word_d.interval     = report ? interval_inc : '0;
    out_word_d.lost_count   = lost_d;
    out_word_d.homed        = homed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q      <= '0;
      count_q     <= '0;
      homed_q     <= 1'b0;
      pos_q       <= '0;
      interval_q  <= '0;
      holdoff_q   <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        home_q     <= home_d;
        count_q    <= count_d;
        homed_q    <= homed_d;
        pos_q      <= pos_d;
        interval_q <= interval_d;
        holdoff_q  <= holdoff_d;
        lost_q     <= lost_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_word_q <= out_word_d;
    end
  end

  `DPPC_ASSERT_NOW(a_report_needs_homed, out_valid_q && out_word_q.report_valid, out_word_q.homed, "report while not homed")
  `DPPC_ASSERT_NOW(a_pos_bounded, out_valid_q, out_word_q.position <= PosLimit + PosWidth'(1), "position beyond limit")
  `DPPC_ASSERT_NOW(a_no_stall_when_empty, !out_valid_q, !in_stall_o, "stall with empty output")
  `DPPC_ASSERT_NEXT(a_report_clears_interval, in_accept && report, interval_q == '0, "interval not cleared after report")
  `DPPC_ASSERT_NEXT(a_report_loads_holdoff, in_accept && report, holdoff_q == $past(holdoff_ticks_q), "holdoff not loaded after report")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

class tick_scoreboard;
  logic [7:0]  home_filt;
  logic [7:0]  count_filt;
  logic [7:0]  holdoff_len;
  logic [15:0] max_cnt;

  logic        home_stable;
  logic        home_cand;
  logic [8:0]  home_conf;
  logic        count_stable;
  logic        count_cand;
  logic [8:0]  count_conf;
  logic        homed;
  logic [10:0] pos;
  logic [15:0] ivl_cnt;
  logic [7:0]  holdoff_left;
  logic [15:0] lost;

  dppc_pkg::out_word_t expected_q[$];
  int errors;

  function new();
    home_filt    = dppc_pkg::HomeFilterRst;
    count_filt   = dppc_pkg::CountFilterRst;
    holdoff_len  = dppc_pkg::HoldoffRst;
    max_cnt      = dppc_pkg::MaxCountRst;
    home_stable  = 1'b0;
    home_cand    = 1'b0;
    home_conf    = '0;
    count_stable = 1'b0;
    count_cand   = 1'b0;
    count_conf   = '0;
    homed        = 1'b0;
    pos          = '0;
    ivl_cnt      = '0;
    holdoff_left = '0;
    lost         = '0;
    errors       = 0;
  endfunction

  function void write_reg(input logic [dppc_pkg::CfgIndexWidth-1:0] idx,
                          input logic [dppc_pkg::CfgDataWidth-1:0] data);
    case (idx)
      dppc_pkg::CfgHomeFilter:  home_filt   = data[7:0];
      dppc_pkg::CfgCountFilter: count_filt  = data[7:0];
      dppc_pkg::CfgHoldoff:     holdoff_len = data[7:0];
      dppc_pkg::CfgMaxCount:    max_cnt     = data;
      default: ;
    endcase
  endfunction

  // returns 1 on an accepted rising level
  function bit filter_step(input logic lvl, input logic [7:0] filt, inout logic stable,
                           inout logic cand, inout logic [8:0] conf);
    if (stable != lvl && conf == '0) cand = lvl;
    if (cand == lvl && cand != stable) begin
      conf = conf + 9'd1;
      if (conf > {1'b0, filt}) begin
        stable = cand;
        conf   = '0;
        return stable;
      end
    end else begin
      cand = stable;
      conf = '0;
    end
    return 1'b0;
  endfunction

  function void note_tick(input dppc_pkg::in_word_t w);
    dppc_pkg::out_word_t o;
    o = '0;
    if (filter_step(w.home_level, home_filt, home_stable, home_cand, home_conf)) begin
      homed = 1'b1;
      pos   = '0;
      lost  = '0;
    end
    ivl_cnt = ivl_cnt + 16'd1;
    if (holdoff_left != '0) begin
      holdoff_left = holdoff_left - 8'd1;
    end else if (filter_step(w.count_level, count_filt, count_stable, count_cand,
                             count_conf)) begin
      if (pos <= dppc_pkg::PosLimit && homed) begin
        pos            = pos + 11'd1;
        o.report_valid = 1'b1;
        o.interval     = ivl_cnt;
        ivl_cnt        = '0;
        holdoff_left   = holdoff_len;
      end
      if (16'(pos) > max_cnt && w.system_enable && lost != dppc_pkg::LostMax)
        lost = lost + 16'd1;
    end
    o.position   = pos;
    o.lost_count = lost;
    o.homed      = homed;
    expected_q.push_back(o);
  endfunction

  function void field_check(input string name, input logic [15:0] exp, input logic [15:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
    end
  endfunction

  function void check_result(input dppc_pkg::out_word_t got);
    dppc_pkg::out_word_t exp;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: word with none pending, expected nothing actual %0h", $time, got);
      return;
    end
    exp = expected_q.pop_front();
    field_check("report_valid", 16'(exp.report_valid), 16'(got.report_valid));
    field_check("position", 16'(exp.position), 16'(got.position));
    field_check("interval", exp.interval, got.interval);
    field_check("lost_count", exp.lost_count, got.lost_count);
    field_check("homed", 16'(exp.homed), 16'(got.homed));
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  dppc_pkg::in_word_t in_word = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [dppc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [dppc_pkg::CfgDataWidth-1:0] cfg_data = '0;

  logic in_stall_o;
  logic out_valid_o;
  dppc_pkg::out_word_t out_word_o;
  logic cfg_ready_o;

  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  tick_scoreboard sb = new();

  logic [dppc_pkg::CfgIndexWidth-1:0] reg_order [4] = '{dppc_pkg::CfgHomeFilter,
    dppc_pkg::CfgCountFilter, dppc_pkg::CfgHoldoff, dppc_pkg::CfgMaxCount};

  // {home, count, enable}
  logic [2:0] opening_ticks [20] = '{3'b011, 3'b001, 3'b100, 3'b000, 3'b100, 3'b100,
    3'b111, 3'b101, 3'b111, 3'b101, 3'b111, 3'b100, 3'b100, 3'b100, 3'b110, 3'b001,
    3'b001, 3'b101, 3'b101, 3'b111};

  debounced_photo_position_counter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) sb.check_result(out_word_o);
      if (in_valid && !in_stall_o) sb.note_tick(in_word);
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic dppc_pkg::in_word_t mk(input logic h, input logic c, input logic e);
    dppc_pkg::in_word_t w;
    w.home_level    = h;
    w.count_level   = c;
    w.system_enable = e;
    return w;
  endfunction

  function automatic int run_len(input int filt, input int spread);
    if (filt > 0 && $urandom_range(0, 6) == 0) return $urandom_range(1, filt);
    return filt + 1 + $urandom_range(0, spread);
  endfunction

  function automatic int pick_filter();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(5, 16);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  task automatic send_tick(input dppc_pkg::in_word_t w);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall_o);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_config(input int hf, input int cf, input int ho, input int mc);
    logic [15:0] vals [4];
    drain();
    vals[0] = {8'($urandom), 8'(hf)};
    vals[1] = {8'($urandom), 8'(cf)};
    vals[2] = {8'($urandom), 8'(ho)};
    vals[3] = 16'(mc);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready_o);
      sb.write_reg(reg_order[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // independent level runs on both sensors, mostly long enough to pass the filters
  task automatic random_ticks(input int n, input bit pause_midway);
    int home_left;
    int count_left;
    logic home_lvl;
    logic count_lvl;
    home_lvl   = 1'($urandom_range(0, 1));
    count_lvl  = 1'($urandom_range(0, 1));
    home_left  = 1;
    count_left = 1;
    for (int i = 0; i < n; i++) begin
      home_left  = home_left - 1;
      count_left = count_left - 1;
      if (home_left == 0) begin
        home_lvl  = ~home_lvl;
        home_left = run_len(sb.home_filt, 150);
      end
      if (count_left == 0) begin
        count_lvl  = ~count_lvl;
        count_left = run_len(sb.count_filt, 3) +
                     ($urandom_range(0, 1) ? int'(sb.holdoff_len) : 0);
      end
      if (pause_midway && i == n / 2) drain();
      send_tick(mk(home_lvl, count_lvl, 1'($urandom_range(0, 9) < 7)));
    end
  endtask

  initial begin
    int mc;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_config(1, 0, 2, 1);
    foreach (opening_ticks[i]) send_tick(dppc_pkg::in_word_t'(opening_ticks[i]));

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 4))
        0: mc = 0;
        1: mc = $urandom_range(1, 40);
        2: mc = 2000;
        3: mc = 65535;
        default: mc = $urandom_range(0, 65535);
      endcase
      set_config(pick_filter(), pick_filter(),
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12), mc);
      gap_pct   = (p % 3 == 2) ? 0 : $urandom_range(5, 30);
      stall_pct = (p % 3 == 1) ? 0 : $urandom_range(5, 30);
      random_ticks(80, p == 4);
    end

    // widest filters and holdoff
    set_config(255, 255, 255, 65535);
    gap_pct   = 5;
    stall_pct = 5;
    random_ticks(300, 1'b0);

    // count on every other word past a zero max count, then home again
    set_config(0, 0, 0, 0);
    gap_pct   = 0;
    stall_pct = 0;
    send_tick(mk(1'b0, 1'b0, 1'b1));
    send_tick(mk(1'b1, 1'b0, 1'b1));
    for (int k = 0; k < 130; k++) begin
      send_tick(mk(1'b1, 1'b1, 1'($urandom_range(0, 31) != 0)));
      send_tick(mk(1'b1, 1'b0, 1'($urandom_range(0, 31) != 0)));
    end
    send_tick(mk(1'b0, 1'b0, 1'b1));
    send_tick(mk(1'b1, 1'b0, 1'b1));
    for (int k = 0; k < 3; k++) begin
      send_tick(mk(1'b1, 1'b1, 1'b1));
      send_tick(mk(1'b1, 1'b0, 1'b0));
    end

    drain();
    repeat (4) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/dppc_pkg.sv
hw/rtl/debounced_photo_position_counter_core.sv
bench/tb.sv
